// File: src/tbld_pkg.sv
// ----------------------------------------------------------------------------
// tbld_pkg
// shared types and constants of the trigger board latch deframer
// ----------------------------------------------------------------------------
package tbld_pkg;

  localparam int unsigned WordW   = 32;
  localparam int unsigned AddrW   = 16;
  localparam int unsigned SizeW   = 8;
  localparam int unsigned CfgIdxW = 8;
  localparam int unsigned CfgW    = 16;

  localparam logic [CfgW-1:0]    CtsAddrLimitRst = 16'h00FF;
  localparam logic [CfgW-1:0]    ExtLimitRst     = 16'd128;
  localparam logic [SizeW-1:0]   MinBlockSize    = 8'd4;

  localparam logic [CfgIdxW-1:0] CfgCtsAddrLimit = 8'd0;
  localparam logic [CfgIdxW-1:0] CfgExtLimit     = 8'd1;

  typedef enum logic [2:0] {
    PH_HEADER     = 3'd0,
    PH_SKIP_HDR   = 3'd1,
    PH_CHECK      = 3'd2,
    PH_EXT_COUNT  = 3'd3,
    PH_SKIP_LATCH = 3'd4,
    PH_LATCH      = 3'd5,
    PH_EMPTY      = 3'd6
  } phase_e;

  typedef enum logic [1:0] {
    KIND_LATCH    = 2'd0,
    KIND_MISMATCH = 2'd1,
    KIND_EXT      = 2'd2,
    KIND_SMALL    = 2'd3
  } kind_e;

  typedef struct packed {
    logic             valid;
    kind_e            kind;
    logic [WordW-1:0] value;
  } result_t;

  typedef struct packed {
    logic [CfgW-1:0] cts_address_limit;
    logic [CfgW-1:0] extension_limit;
  } cfg_t;

endpackage

// File: src/trigger_board_latch_deframer.sv
// ----------------------------------------------------------------------------
// flow: a word waits in the input register until the parser steps, which
// registers its result; the step waits while a pending result is held by the receiver
// throughput: one word per cycle while no pending result is held, set by the
// parser step between the input register and the result register
// reset: clears parser state and valids, limits return to 255 and 128
// ----------------------------------------------------------------------------
// trigger_board_latch_deframer
// extracts latch words from trigger board blocks of a subevent
// ----------------------------------------------------------------------------
module trigger_board_latch_deframer (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [tbld_pkg::WordW-1:0]    word_i,
  input  logic                          first_of_subevent_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [1:0]                    kind_o,
  output logic [tbld_pkg::WordW-1:0]    value_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [tbld_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [tbld_pkg::CfgW-1:0]     cfg_data_i
);

  logic                       in_valid_q;
  logic [tbld_pkg::WordW-1:0] word_q;
  logic                       first_q;
  logic                       advance;
  logic                       out_valid_q, out_valid_d;
  tbld_pkg::kind_e            kind_q;
  logic [tbld_pkg::WordW-1:0] value_q;
  tbld_pkg::cfg_t             cfg_q;
  tbld_pkg::result_t          res;

  assign advance     = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o  = !in_valid_q || advance;
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;
  assign kind_o      = kind_q;
  assign value_o     = value_q;
  assign out_valid_d = advance ? res.valid : (out_valid_q && !out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.cts_address_limit <= tbld_pkg::CtsAddrLimitRst;
      cfg_q.extension_limit   <= tbld_pkg::ExtLimitRst;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        tbld_pkg::CfgCtsAddrLimit: cfg_q.cts_address_limit <= cfg_data_i;
        tbld_pkg::CfgExtLimit:     cfg_q.extension_limit   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_ready_o ? in_valid_i : in_valid_q;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      word_q  <= word_i;
      first_q <= first_of_subevent_i;
    end
    if (advance && res.valid) begin
      kind_q  <= res.kind;
      value_q <= res.value;
    end
  end

  tbld_parse u_parse (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .step_i  (advance),
    .word_i  (word_q),
    .first_i (first_q),
    .cfg_i   (cfg_q),
    .res_o   (res)
  );

`ifndef SYNTHESIS
  a_stall_only_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> in_valid_q && out_valid_q && !out_ready_i)
    else $error("input stalled without a full pipe");

  a_result_kept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_ready_i |=> out_valid_q && $stable(value_q))
    else $error("pending result lost");

  a_result_from_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_q ##1 out_valid_q |-> $past(advance) && $past(res.valid))
    else $error("result without a parser step");
`endif

endmodule

// File: src/tbld_parse.sv
// ----------------------------------------------------------------------------
// tbld_parse
// block parser: phase, skip counter, block size and halt flag, one word per step
// ----------------------------------------------------------------------------
module tbld_parse (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      step_i,
  input  logic [tbld_pkg::WordW-1:0] word_i,
  input  logic                      first_i,
  input  tbld_pkg::cfg_t            cfg_i,
  output tbld_pkg::result_t         res_o
);

  tbld_pkg::phase_e                 phase_q, phase_d, cur_phase;
  logic [tbld_pkg::AddrW-1:0]       words_left_q, words_left_d, cur_left, left_dec;
  logic [tbld_pkg::SizeW-1:0]       block_size_q, block_size_d, hdr_size, scaler_cnt;
  logic                             halted_q, halted_d, cur_halted;
  logic [tbld_pkg::AddrW-1:0]       ext_cnt;

  assign cur_phase  = first_i ? tbld_pkg::PH_HEADER : phase_q;
  assign cur_left   = first_i ? '0 : words_left_q;
  assign cur_halted = halted_q && !first_i;
  assign left_dec   = cur_left - {{(tbld_pkg::AddrW-1){1'b0}}, 1'b1};
  assign hdr_size   = word_i[23:16];
  assign ext_cnt    = word_i[tbld_pkg::AddrW-1:0];
  assign scaler_cnt = block_size_q - tbld_pkg::MinBlockSize;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= tbld_pkg::PH_HEADER;
      words_left_q <= '0;
      block_size_q <= '0;
      halted_q     <= 1'b0;
    end else begin
      phase_q      <= phase_d;
      words_left_q <= words_left_d;
      block_size_q <= block_size_d;
      halted_q     <= halted_d;
    end
  end

  always_comb begin
    phase_d      = phase_q;
    words_left_d = words_left_q;
    block_size_d = block_size_q;
    halted_d     = halted_q;
    res_o        = '0;
    if (step_i) begin
      phase_d      = cur_phase;
      words_left_d = cur_left;
      halted_d     = cur_halted;
      if (!cur_halted) begin
        case (cur_phase)
          tbld_pkg::PH_SKIP_HDR, tbld_pkg::PH_SKIP_LATCH: begin
            words_left_d = left_dec;
            if (left_dec == '0) begin
              phase_d = (cur_phase == tbld_pkg::PH_SKIP_HDR) ? tbld_pkg::PH_HEADER
                                                             : tbld_pkg::PH_LATCH;
            end
          end
          tbld_pkg::PH_CHECK: begin
            if (word_i[tbld_pkg::SizeW-1:0] != block_size_q) begin
              res_o        = '{valid: 1'b1, kind: tbld_pkg::KIND_MISMATCH, value: word_i};
              halted_d     = 1'b1;
              phase_d      = tbld_pkg::PH_HEADER;
              words_left_d = '0;
            end else begin
              phase_d = tbld_pkg::PH_EXT_COUNT;
            end
          end
          tbld_pkg::PH_EXT_COUNT: begin
            if (ext_cnt != '0 && ext_cnt >= cfg_i.extension_limit) begin
              res_o        = '{valid: 1'b1, kind: tbld_pkg::KIND_EXT, value: word_i};
              halted_d     = 1'b1;
              phase_d      = tbld_pkg::PH_HEADER;
              words_left_d = '0;
            end else if (ext_cnt != '0) begin
              words_left_d = ext_cnt;
              phase_d      = tbld_pkg::PH_SKIP_LATCH;
            end else begin
              phase_d = tbld_pkg::PH_LATCH;
            end
          end
          tbld_pkg::PH_LATCH: begin
            res_o   = '{valid: 1'b1, kind: tbld_pkg::KIND_LATCH, value: word_i};
            phase_d = tbld_pkg::PH_EMPTY;
          end
          tbld_pkg::PH_EMPTY: begin
            if (scaler_cnt != '0) begin
              words_left_d = {{(tbld_pkg::AddrW-tbld_pkg::SizeW){1'b0}}, scaler_cnt};
              phase_d      = tbld_pkg::PH_SKIP_HDR;
            end else begin
              phase_d = tbld_pkg::PH_HEADER;
            end
          end
          default: begin
            block_size_d = hdr_size;
            if (word_i[tbld_pkg::AddrW-1:0] > cfg_i.cts_address_limit) begin
              if (hdr_size != '0) begin
                words_left_d = {{(tbld_pkg::AddrW-tbld_pkg::SizeW){1'b0}}, hdr_size};
                phase_d      = tbld_pkg::PH_SKIP_HDR;
              end else begin
                phase_d = tbld_pkg::PH_HEADER;
              end
            end else if (hdr_size < tbld_pkg::MinBlockSize) begin
              res_o        = '{valid: 1'b1, kind: tbld_pkg::KIND_SMALL, value: word_i};
              halted_d     = 1'b1;
              phase_d      = tbld_pkg::PH_HEADER;
              words_left_d = '0;
            end else begin
              phase_d = tbld_pkg::PH_CHECK;
            end
          end
        endcase
      end
    end
  end

`ifndef SYNTHESIS
  a_err_halts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && res_o.valid && res_o.kind != tbld_pkg::KIND_LATCH |=> halted_q)
    else $error("error result did not halt the parser");

  a_halted_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    halted_q && !first_i |-> !res_o.valid)
    else $error("result while halted");

  a_halted_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    halted_q |-> phase_q == tbld_pkg::PH_HEADER && words_left_q == '0)
    else $error("halted with a block in progress");
`endif

endmodule
